// ----- src/tws_pkg.sv -----
// -----------------------------------------------------------------------------
// Timer wheel scheduler package
// Shared constants, codes, types and a helper function for the timer wheel.
// -----------------------------------------------------------------------------
package tws_pkg;

    localparam int NUM_TIMERS = 32;
    localparam int SLOTS      = 64;

    // field widths
    localparam int KIND_W   = 2;
    localparam int ID_W     = 5;
    localparam int PERIOD_W = 16;
    localparam int OPT_W    = 3;
    localparam int STAT_W   = 3;
    localparam int TICK_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // derived widths
    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int ACT_W  = $clog2(NUM_TIMERS + 1);
    localparam int CNT_W  = $clog2(PERIOD_W);

    // register reset values
    localparam logic [TICK_W-1:0]   TICK_MS_RST    = TICK_W'(10);
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(630);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = CFG_IDX_W'(1);

    // option bits
    localparam int OPT_ONCE    = 0;
    localparam int OPT_PERSIST = 1;
    localparam int OPT_IMM     = 2;

    typedef enum logic [KIND_W-1:0] {
        K_ADD    = 2'd0,
        K_DELETE = 2'd1,
        K_TICK   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_ON_WHEEL    = 3'd1,
        ST_BAD_PERIOD  = 3'd2,
        ST_BAD_OPTIONS = 3'd3,
        ST_NO_HANDLER  = 3'd4
    } t_status;

    localparam logic EV_STATUS = 1'b0;
    localparam logic EV_EXPIRY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADD_CHK,
        S_IMM,
        S_PLACE,
        S_DEL,
        S_SCAN,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic              on_wheel;
        logic              persist;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] offset;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_tbl_wr;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quo;
        logic                rem_zero;
    } t_div_out;

    // (cur + off) mod SLOTS, both operands below SLOTS
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] cur,
                                                    input logic [SLOT_W-1:0] off);
        logic [SLOT_W:0] sum;
        sum = {1'b0, cur} + {1'b0, off};
        if (sum >= (SLOT_W+1)'(SLOTS)) begin
            sum = sum - (SLOT_W+1)'(SLOTS);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

// ----- src/tws_if.sv -----
// -----------------------------------------------------------------------------
// Timer wheel channel interfaces
// Request, result and configuration write channels with valid/ready.
// -----------------------------------------------------------------------------
interface tws_req_if;
    import tws_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] period_ms;
    logic [OPT_W-1:0]    options;
    logic                handler_valid;

    modport source (output valid, kind, timer_id, period_ms, options, handler_valid,
                    input ready);
    modport sink   (input valid, kind, timer_id, period_ms, options, handler_valid,
                    output ready);
endinterface

interface tws_res_if;
    import tws_pkg::*;
    logic              valid;
    logic              ready;
    logic              event_res;
    logic [ID_W-1:0]   expired_id;
    logic [STAT_W-1:0] status;
    logic [ACT_W-1:0]  active_count;
    logic              last;

    modport source (output valid, event_res, expired_id, status, active_count, last,
                    input ready);
    modport sink   (input valid, event_res, expired_id, status, active_count, last,
                    output ready);
endinterface

interface tws_cfg_if;
    import tws_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/tws_divider.sv -----
// -----------------------------------------------------------------------------
// Timer wheel period divider
// Restoring divider, one quotient bit per cycle, period by tick length.
// -----------------------------------------------------------------------------
module tws_divider
    import tws_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_dividend,
    input  logic [TICK_W-1:0]   i_divisor,
    output t_div_out            o_div
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_num;
    logic [TICK_W-1:0]   r_rem;
    logic [TICK_W-1:0]   r_den;

    logic [TICK_W:0]     w_rem_sh;
    logic [TICK_W:0]     w_diff;
    logic                w_ge;
    logic [TICK_W-1:0]   n_rem;

    always_comb begin
        w_rem_sh = {r_rem, r_num[PERIOD_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
        n_rem    = w_ge ? w_diff[TICK_W-1:0] : w_rem_sh[TICK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PERIOD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[PERIOD_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_div.done     = r_done;
    assign o_div.quo      = r_num;
    assign o_div.rem_zero = (r_rem == '0);

endmodule

// ----- src/tws_table.sv -----
// -----------------------------------------------------------------------------
// Timer wheel entry table
// Per-timer state with one read port and one write port.
// -----------------------------------------------------------------------------
module tws_table
    import tws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  t_tbl_wr          i_wr,
    output t_entry           o_rd
);

    logic [NUM_TIMERS-1:0] r_on_wheel;
    logic [NUM_TIMERS-1:0] r_persist;
    logic [SLOT_W-1:0]     r_slot   [NUM_TIMERS];
    logic [SLOT_W-1:0]     r_offset [NUM_TIMERS];

    // control bits: clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_wheel <= '0;
            r_persist  <= '0;
        end else if (i_wr.en) begin
            r_on_wheel[i_wr.idx] <= i_wr.entry.on_wheel;
            r_persist[i_wr.idx]  <= i_wr.entry.persist;
        end
    end

    // slot and offset are read only while the entry is on the wheel
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_slot[i_wr.idx]   <= i_wr.entry.slot;
            r_offset[i_wr.idx] <= i_wr.entry.offset;
        end
    end

    assign o_rd.on_wheel = r_on_wheel[i_rd_idx];
    assign o_rd.persist  = r_persist[i_rd_idx];
    assign o_rd.slot     = r_slot[i_rd_idx];
    assign o_rd.offset   = r_offset[i_rd_idx];

endmodule

// ----- src/timer_wheel_scheduler.sv -----
// -----------------------------------------------------------------------------
// Timer wheel scheduler
// Hashed timing wheel: add, delete and tick requests over a table of timers.
// -----------------------------------------------------------------------------
// One request is handled at a time; the request channel is ready only while
// the sequencer is idle. Every request ends with one status result (last=1)
// that carries the number of timers on the wheel. An add passes through the
// bit-serial divider, which forms period / tick length and flags a zero
// remainder, and an immediate expiry adds one expiry result before the
// status; a delete clears the entry if it is on the wheel; in a tick, one
// table read port walks the entries in ascending index and emits an expiry
// for each hit. A stalled result output holds the walk in place.
// Configuration writes are accepted on every cycle and must land only while
// the block is idle. The on-wheel and persist bits of the timer table are
// cleared at reset; no clearing pass is needed.
// -----------------------------------------------------------------------------
module timer_wheel_scheduler
    import tws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tws_req_if.sink   i_req,
    tws_res_if.source o_res,
    tws_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [TICK_W-1:0]   r_tick_ms;
    logic [PERIOD_W-1:0] r_max_period;

    // sequencer and request context
    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_id_ok, n_id_ok;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [OPT_W-1:0]    r_opt, n_opt;
    logic                r_handler, n_handler;
    t_status             r_st, n_st;
    logic [SLOT_W-1:0]   r_cur, n_cur;
    logic [ACT_W-1:0]    r_active, n_active;

    // output register
    logic                r_out_valid;
    logic                r_out_ev;
    logic [ID_W-1:0]     r_out_id;
    logic [STAT_W-1:0]   r_out_st;
    logic [ACT_W-1:0]    r_out_cnt;
    logic                r_out_last;

    logic                w_load;
    logic                w_load_ev;
    logic [ID_W-1:0]     w_load_id;
    logic [STAT_W-1:0]   w_load_st;
    logic [ACT_W-1:0]    w_load_cnt;
    logic                w_load_last;

    logic                w_room;
    logic                w_accept;
    logic                w_div_start;
    t_div_out            w_div;
    t_tbl_wr             w_wr;
    t_entry              w_rd;
    logic                w_bad_period;
    t_status             w_add_st;
    logic                w_hit;
    logic                w_scan_end;

    tws_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_req.period_ms),
        .i_divisor  (r_tick_ms),
        .o_div      (w_div)
    );

    tws_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_idx),
        .i_wr     (w_wr),
        .o_rd     (w_rd)
    );

    // configuration port: always ready, index beyond the list is dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_ms    <= TICK_MS_RST;
            r_max_period <= MAX_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TICK_MS:    r_tick_ms    <= i_cfg.data[TICK_W-1:0];
                CFG_MAX_PERIOD: r_max_period <= i_cfg.data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_room      = !r_out_valid || o_res.ready;

    // add checks, evaluated once the divider is done
    always_comb begin
        w_bad_period = (r_tick_ms == '0) || (r_period == '0) ||
                       (r_period > r_max_period) || !w_div.rem_zero ||
                       (w_div.quo >= PERIOD_W'(SLOTS));
        if (!r_id_ok) begin
            w_add_st = ST_OK;
        end else if (w_rd.on_wheel) begin
            w_add_st = ST_ON_WHEEL;
        end else if (w_bad_period) begin
            w_add_st = ST_BAD_PERIOD;
        end else if (r_opt[OPT_ONCE] && r_opt[OPT_PERSIST]) begin
            w_add_st = ST_BAD_OPTIONS;
        end else if (!r_handler) begin
            w_add_st = ST_NO_HANDLER;
        end else begin
            w_add_st = ST_OK;
        end
    end

    assign w_hit      = w_rd.on_wheel && (w_rd.slot == r_cur);
    assign w_scan_end = (r_idx == IDX_W'(NUM_TIMERS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    case (t_kind'(i_req.kind))
                        K_ADD:    n_state = S_DIV;
                        K_DELETE: n_state = S_DEL;
                        K_TICK:   n_state = S_SCAN;
                        default:  n_state = S_STATUS;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_state = S_ADD_CHK;
                end
            end
            S_ADD_CHK: begin
                if (!r_id_ok || w_add_st != ST_OK) begin
                    n_state = S_STATUS;
                end else if (r_opt[OPT_IMM]) begin
                    n_state = S_IMM;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_IMM: begin
                if (w_room) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE:  n_state = S_STATUS;
            S_DEL:    n_state = S_STATUS;
            S_SCAN: begin
                if ((!w_hit || w_room) && w_scan_end) begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (w_room) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath, table writes and result loads
    always_comb begin
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_id_ok     = r_id_ok;
        n_period    = r_period;
        n_opt       = r_opt;
        n_handler   = r_handler;
        n_st        = r_st;
        n_cur       = r_cur;
        n_active    = r_active;
        w_div_start = 1'b0;
        w_wr        = '0;
        w_wr.idx    = r_idx;
        w_wr.entry  = w_rd;
        w_load      = 1'b0;
        w_load_ev   = EV_STATUS;
        w_load_id   = '0;
        w_load_st   = ST_OK;
        w_load_cnt  = r_active;
        w_load_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind    = t_kind'(i_req.kind);
                    n_period  = i_req.period_ms;
                    n_opt     = i_req.options;
                    n_handler = i_req.handler_valid;
                    n_id_ok   = ({1'b0, i_req.timer_id} < (ID_W+1)'(NUM_TIMERS));
                    n_st      = ST_OK;
                    if (t_kind'(i_req.kind) == K_TICK) begin
                        // advance the wheel and start the walk at entry zero
                        n_idx = '0;
                        n_cur = (r_cur == SLOT_W'(SLOTS - 1)) ? '0 : r_cur + SLOT_W'(1);
                    end else begin
                        n_idx = IDX_W'(i_req.timer_id);
                    end
                    w_div_start = (t_kind'(i_req.kind) == K_ADD);
                end
            end
            S_ADD_CHK: begin
                n_st = w_add_st;
            end
            S_IMM: begin
                // immediate expiry: count does not yet include the new timer
                if (w_room) begin
                    w_load    = 1'b1;
                    w_load_ev = EV_EXPIRY;
                    w_load_id = ID_W'(r_idx);
                end
            end
            S_PLACE: begin
                w_wr.en             = 1'b1;
                w_wr.entry.on_wheel = 1'b1;
                w_wr.entry.persist  = r_opt[OPT_PERSIST];
                w_wr.entry.offset   = w_div.quo[SLOT_W-1:0];
                w_wr.entry.slot     = wrap_slot(r_cur, w_div.quo[SLOT_W-1:0]);
                n_active            = r_active + ACT_W'(1);
            end
            S_DEL: begin
                if (r_id_ok && w_rd.on_wheel) begin
                    w_wr.en             = 1'b1;
                    w_wr.entry.on_wheel = 1'b0;
                    n_active            = r_active - ACT_W'(1);
                end
            end
            S_SCAN: begin
                if (w_hit && w_room) begin
                    // persistent: rearm one period ahead; one-shot: drop first
                    w_wr.en = 1'b1;
                    if (w_rd.persist) begin
                        w_wr.entry.slot = wrap_slot(r_cur, w_rd.offset);
                    end else begin
                        w_wr.entry.on_wheel = 1'b0;
                        n_active            = r_active - ACT_W'(1);
                    end
                    w_load     = 1'b1;
                    w_load_ev  = EV_EXPIRY;
                    w_load_id  = ID_W'(r_idx);
                    w_load_cnt = n_active;
                end
                if ((!w_hit || w_room) && !w_scan_end) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_STATUS: begin
                if (w_room) begin
                    w_load      = 1'b1;
                    w_load_st   = r_st;
                    w_load_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_active <= n_active;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_idx     <= n_idx;
        r_id_ok   <= n_id_ok;
        r_period  <= n_period;
        r_opt     <= n_opt;
        r_handler <= n_handler;
        r_st      <= n_st;
        if (w_load) begin
            r_out_ev   <= w_load_ev;
            r_out_id   <= w_load_id;
            r_out_st   <= w_load_st;
            r_out_cnt  <= w_load_cnt;
            r_out_last <= w_load_last;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_out_ev;
    assign o_res.expired_id   = r_out_id;
    assign o_res.status       = r_out_st;
    assign o_res.active_count = r_out_cnt;
    assign o_res.last         = r_out_last;

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // add checks only run on a finished quotient
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (n_state == S_ADD_CHK) |-> w_div.done)
        else $error("add check entered before divider finished");

    // placing a timer grows the active count by one
    a_place_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLACE) |=> (r_active == $past(r_active) + ACT_W'(1)))
        else $error("active count not incremented on place");

    // the final result of a request is always a status result
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.event_res == EV_STATUS))
        else $error("last result is not a status result");

    // the active count never exceeds the table size while a request is in progress
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_active <= ACT_W'(NUM_TIMERS)))
        else $error("active count out of range");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Timer wheel scheduler testbench
// Drives add, delete, tick and unused-kind requests through the request channel under
// several register settings and idle patterns. A scoreboard mirrors the wheel
// and checks every result, field by field and in order.
// -----------------------------------------------------------------------------
module tb_top
    import tws_pkg::*;
();

    // idle cycles with no handshake at all before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 4000;
    // longest request (a full table walk) plus margin
    localparam int QUIET_CYCLES    = 40;
    // long receiver hold-off used to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;

    // register indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic              ev;
        logic [ID_W-1:0]   id;
        logic [STAT_W-1:0] st;
        logic [ACT_W-1:0]  act;
        logic              last;
    } t_wheel_result;

    // -------------------------------------------------------------------------
    // Scoreboard: own copy of the wheel, predicts results per accepted request
    // -------------------------------------------------------------------------
    class t_wheel_scoreboard;
        logic [TICK_W-1:0]   tick_ms;
        logic [PERIOD_W-1:0] max_period;
        bit                  on_wheel [NUM_TIMERS];
        bit                  persist  [NUM_TIMERS];
        logic [SLOT_W-1:0]   slot     [NUM_TIMERS];
        logic [SLOT_W-1:0]   offset   [NUM_TIMERS];
        logic [SLOT_W-1:0]   wheel_pos;
        int unsigned         active;
        t_wheel_result       expected_q[$];
        int                  errors;
        int                  kind_seen[4];
        int                  expiries;
        int                  rejected;
        int                  results_checked;
        int                  max_burst;

        function new();
            tick_ms    = TICK_MS_RST;
            max_period = MAX_PERIOD_RST;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                on_wheel[i] = 1'b0;
                persist[i]  = 1'b0;
                slot[i]     = '0;
                offset[i]   = '0;
            end
            wheel_pos = '0;
            active   = 0;
            errors   = 0;
            expiries = 0;
            rejected = 0;
            results_checked = 0;
            max_burst = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TICK_MS) begin
                tick_ms = data[TICK_W-1:0];
            end else if (idx == CFG_MAX_PERIOD) begin
                max_period = data[PERIOD_W-1:0];
            end
        endfunction

        function void push_result(logic ev, logic [ID_W-1:0] id, t_status st, logic last);
            t_wheel_result r;
            r.ev   = ev;
            r.id   = id;
            r.st   = st;
            r.act  = ACT_W'(active);
            r.last = last;
            expected_q.push_back(r);
            if (ev == EV_EXPIRY) begin
                expiries++;
            end
        endfunction

        function void note_request(t_kind kind, logic [ID_W-1:0] id,
                                   logic [PERIOD_W-1:0] period, logic [OPT_W-1:0] opts,
                                   logic handler);
            int unsigned p;
            int unsigned t;
            int unsigned offs;
            int          burst;
            bit          bad;
            t_status     st;
            p     = period;
            t     = tick_ms;
            offs  = 0;
            burst = 1;
            st    = ST_OK;
            kind_seen[int'(kind)]++;
            case (kind)
                K_ADD: begin
                    bad = (t == 0) || (p == 0) || (period > max_period);
                    if (!bad) begin
                        if (p % t != 0) begin
                            bad = 1'b1;
                        end else begin
                            offs = p / t;
                            if (offs >= SLOTS) bad = 1'b1;
                        end
                    end
                    if (on_wheel[id]) begin
                        st = ST_ON_WHEEL;
                    end else if (bad) begin
                        st = ST_BAD_PERIOD;
                    end else if (opts[OPT_ONCE] && opts[OPT_PERSIST]) begin
                        st = ST_BAD_OPTIONS;
                    end else if (!handler) begin
                        st = ST_NO_HANDLER;
                    end else begin
                        // immediate expiry goes out before the timer counts as active
                        if (opts[OPT_IMM]) begin
                            push_result(EV_EXPIRY, id, ST_OK, 1'b0);
                            burst++;
                        end
                        persist[id]  = opts[OPT_PERSIST];
                        offset[id]   = SLOT_W'(offs);
                        slot[id]     = SLOT_W'((int'(wheel_pos) + offs) % SLOTS);
                        on_wheel[id] = 1'b1;
                        active++;
                    end
                    if (st != ST_OK) rejected++;
                end
                K_DELETE: begin
                    if (on_wheel[id]) begin
                        on_wheel[id] = 1'b0;
                        active--;
                    end
                end
                K_TICK: begin
                    wheel_pos = SLOT_W'((int'(wheel_pos) + 1) % SLOTS);
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (on_wheel[i] && slot[i] == wheel_pos) begin
                            if (persist[i]) begin
                                slot[i] = SLOT_W'((int'(wheel_pos) + int'(offset[i])) % SLOTS);
                            end else begin
                                // one-shot leaves the count before its expiry is reported
                                on_wheel[i] = 1'b0;
                                active--;
                            end
                            push_result(EV_EXPIRY, ID_W'(i), ST_OK, 1'b0);
                            burst++;
                        end
                    end
                end
                default: ;
            endcase
            push_result(EV_STATUS, '0, st, 1'b1);
            if (burst > max_burst) max_burst = burst;
        endfunction

        function void check_result(t_wheel_result got);
            t_wheel_result want;
            results_checked++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: event_res %0d expired_id %0d status %0d active %0d",
                       got.ev, got.id, got.st, got.act);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ev !== want.ev) begin
                $error("event_res mismatch: expected %0d, actual %0d", want.ev, got.ev);
                errors++;
            end
            if (got.id !== want.id) begin
                $error("expired_id mismatch: expected %0d, actual %0d", want.id, got.id);
                errors++;
            end
            if (got.st !== want.st) begin
                $error("status mismatch: expected %0d, actual %0d", want.st, got.st);
                errors++;
            end
            if (got.act !== want.act) begin
                $error("active_count mismatch: expected %0d, actual %0d", want.act, got.act);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // -------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    tws_req_if req_ch();
    tws_res_if res_ch();
    tws_cfg_if cfg_ch();

    timer_wheel_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_wheel_scoreboard sb;

    int send_idle_pct;      // chance in 100 that the sender skips a cycle
    int recv_stall_pct;     // chance in 100 that the receiver drops ready
    int hold_left;          // remaining cycles of a long receiver hold-off
    int idle_cycles;
    int settings_used;

    // -------------------------------------------------------------------------
    // Receiver: drop ready at random, or hold it low through a long hold-off
    // -------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: hand every accepted result to the scoreboard
    always @(posedge i_clk) begin
        t_wheel_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.ev   = res_ch.event_res;
            got.id   = res_ch.expired_id;
            got.st   = res_ch.status;
            got.act  = res_ch.active_count;
            got.last = res_ch.last;
            sb.check_result(got);
        end
    end

    // Watchdog: end the run if no channel moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results still awaited",
                     idle_cycles, sb.pending());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Drivers
    // -------------------------------------------------------------------------

    // Offer one request; hold it until accepted, then note it for prediction.
    task automatic send_request(input t_kind kind, input logic [ID_W-1:0] id,
                                input logic [PERIOD_W-1:0] period,
                                input logic [OPT_W-1:0] opts, input logic handler);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.timer_id      <= id;
        req_ch.period_ms     <= period;
        req_ch.options       <= opts;
        req_ch.handler_valid <= handler;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sb.note_request(kind, id, period, opts, handler);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.write_register(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering, wait for every awaited result, then let the block settle.
    task automatic drain_wheel();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int tick, input int max_period);
        write_register(CFG_TICK_MS, CFG_DATA_W'(tick));
        write_register(CFG_MAX_PERIOD, CFG_DATA_W'(max_period));
        settings_used++;
    endtask

    // A period the current setting accepts, or noise if none exists.
    function automatic logic [PERIOD_W-1:0] legal_period();
        int t;
        int kmax;
        t    = sb.tick_ms;
        kmax = (t == 0) ? 0 : int'(sb.max_period) / t;
        if (kmax > SLOTS - 1) kmax = SLOTS - 1;
        if (kmax == 0) return PERIOD_W'($urandom);
        return PERIOD_W'(t * $urandom_range(1, kmax));
    endfunction

    // Mostly well-formed adds and ticks, with some noise and broken adds.
    task automatic send_random_request();
        int                  pick;
        int                  flavor;
        t_kind               kind;
        logic [PERIOD_W-1:0] period;
        logic [OPT_W-1:0]    opts;
        logic                handler;
        pick    = $urandom_range(0, 99);
        flavor  = $urandom_range(0, 99);
        period  = PERIOD_W'($urandom);
        opts    = OPT_W'($urandom_range(0, 7));
        handler = 1'($urandom_range(0, 1));
        if (pick < 42)      kind = K_ADD;
        else if (pick < 55) kind = K_DELETE;
        else if (pick < 95) kind = K_TICK;
        else                kind = K_NONE;
        if (kind == K_ADD) begin
            if (flavor < 75) begin
                // well-formed: legal period, never once together with persist
                period  = legal_period();
                handler = 1'b1;
                if (opts[OPT_PERSIST:OPT_ONCE] == 2'b11) begin
                    opts[OPT_PERSIST:OPT_ONCE] = 2'($urandom_range(0, 2));
                end
            end else if (flavor < 88) begin
                // broken: legal period, but conflicting options or no handler
                period = legal_period();
                if ($urandom_range(0, 1)) begin
                    opts[OPT_PERSIST:OPT_ONCE] = 2'b11;
                end else begin
                    handler = 1'b0;
                end
            end
            // remaining flavor: raw noise in every field
        end
        send_request(kind, ID_W'($urandom_range(0, NUM_TIMERS - 1)), period, opts, handler);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_request();
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // -------------------------------------------------------------------------
    // Sequence of phases
    // -------------------------------------------------------------------------
    initial begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        idle_cycles    = 0;
        settings_used  = 1;

        // drive every input to a known value before the first edge
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = K_NONE;
        req_ch.timer_id      = '0;
        req_ch.period_ms     = '0;
        req_ch.options       = '0;
        req_ch.handler_valid = 1'b0;
        res_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_TICK_MS;
        cfg_ch.data          = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values (10 ms ticks, 630 ms ceiling).
        send_request(K_DELETE, 5'd0, 16'd0, 3'b000, 1'b0);       // delete of an idle timer
        send_request(K_ADD, 5'd0, 16'd0, 3'b000, 1'b1);          // zero period
        send_request(K_ADD, 5'd1, 16'd15, 3'b000, 1'b1);         // not a tick multiple
        send_request(K_ADD, 5'd2, 16'd640, 3'b000, 1'b1);        // above the ceiling
        send_request(K_ADD, 5'd3, 16'd10, 3'b011, 1'b1);         // once with persist
        send_request(K_ADD, 5'd4, 16'd10, 3'b000, 1'b0);         // no handler
        send_request(K_ADD, 5'd5, 16'd10, 3'b100, 1'b1);         // immediate expiry
        send_request(K_ADD, 5'd5, 16'd20, 3'b000, 1'b1);         // already on the wheel
        send_request(K_ADD, 5'd31, 16'd630, 3'b110, 1'b1);       // largest offset, persistent
        send_request(K_ADD, 5'd6, 16'd20, 3'b001, 1'b1);         // one-shot
        send_request(K_ADD, 5'd7, 16'd10, 3'b010, 1'b1);         // persistent, every tick
        send_request(K_TICK, 5'd0, 16'd0, 3'b000, 1'b0);
        send_request(K_TICK, 5'd0, 16'd0, 3'b000, 1'b0);
        send_request(K_DELETE, 5'd7, 16'hFFFF, 3'b111, 1'b1);
        send_request(K_DELETE, 5'd7, 16'd0, 3'b000, 1'b0);
        send_request(K_NONE, 5'd31, 16'hFFFF, 3'b111, 1'b1);     // unused kind
        send_request(K_ADD, 5'd8, 16'hFFFF, 3'b111, 1'b1);       // all ones, bad period
        send_request(K_ADD, 5'd9, 16'd10, 3'b111, 1'b1);         // conflict with immediate
        send_request(K_TICK, 5'd0, 16'd0, 3'b000, 1'b0);
        drain_wheel();

        // Defaults, no idling on either side.
        run_random(60);
        drain_wheel();

        // 1 ms ticks, widest ceiling; sender idles often.
        apply_setting(1, 65535);
        set_idling(60, 0);
        send_request(K_ADD, 5'd10, 16'd64, 3'b000, 1'b1);        // offset of SLOTS
        send_request(K_ADD, 5'd11, 16'd63, 3'b010, 1'b1);
        run_random(50);
        drain_wheel();

        // 1 s ticks; receiver stalls often.
        apply_setting(1000, 65535);
        set_idling(0, 60);
        send_request(K_ADD, 5'd12, 16'd64000, 3'b000, 1'b1);     // offset of SLOTS
        send_request(K_ADD, 5'd13, 16'd63000, 3'b001, 1'b1);
        run_random(50);
        drain_wheel();

        // Odd tick, low ceiling; spare register indexes must be ignored.
        // Both sides idle, and the receiver first holds off long enough for
        // the block to back up and refuse requests.
        apply_setting(7, 200);
        write_register(CFG_SPARE_A, 16'hFFFF);
        write_register(CFG_SPARE_B, 16'h0001);
        set_idling(38, 38);
        hold_left = HOLD_OFF_CYCLES;
        run_random(100);
        drain_wheel();

        // Ceiling of 1 ms: fill every table entry into the same slot so that
        // one tick expires the whole table.
        apply_setting(1, 1);
        set_idling(0, 0);
        for (int i = 0; i < NUM_TIMERS; i++) begin
            send_request(K_DELETE, ID_W'(i), 16'd0, 3'b000, 1'b0);
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
            send_request(K_ADD, ID_W'(i), 16'd1, 3'b010, 1'b1);
        end
        send_request(K_TICK, 5'd0, 16'd0, 3'b000, 1'b0);
        run_random(40);
        drain_wheel();

        // Zero tick length: every add is refused, ticks still fire.
        apply_setting(0, 65535);
        set_idling(38, 38);
        run_random(15);
        drain_wheel();

        // Back to the reset values; receiver stalls often.
        apply_setting(int'(TICK_MS_RST), int'(MAX_PERIOD_RST));
        set_idling(0, 60);
        run_random(30);
        drain_wheel();

        $display("covered %0d adds, %0d deletes, %0d ticks, %0d unused kinds over %0d settings",
                 sb.kind_seen[int'(K_ADD)], sb.kind_seen[int'(K_DELETE)],
                 sb.kind_seen[int'(K_TICK)], sb.kind_seen[int'(K_NONE)], settings_used);
        $display("checked %0d results: %0d expiries, %0d refused adds, up to %0d per request",
                 sb.results_checked, sb.expiries, sb.rejected, sb.max_burst);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/tws_pkg.sv
src/tws_if.sv
src/tws_divider.sv
src/tws_table.sv
src/timer_wheel_scheduler.sv
bench/tb_top.sv
